// ===== rtl/core/rse_pkg.sv =====
// Package for the Reed-Solomon parity generator: sizes, FSM and command types,
// and GF(2^8) arithmetic helpers. No dependencies.
`default_nettype none

package rse_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int CNT_W      = $clog2(MAX_DEGREE);
    localparam int DEG_W      = 6;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] GF_POLY   = 8'h1D; // x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [DEG_W-1:0]  DEG_RESET = 6'd10;

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_DERIVE = 4'b0010,
        ST_IDLE   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic             init;
        logic             derive;
        logic             absorb;
        logic             emit;
        logic             emit_last;
        logic [CNT_W-1:0] deg_m1;
    } cmd_t;

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        acc = '0;
        for (int bit_idx = BYTE_W - 1; bit_idx >= 0; bit_idx--)
        begin
            acc = {acc[BYTE_W-2:0], 1'b0} ^ (acc[BYTE_W-1] ? GF_POLY : '0);
            if (b[bit_idx])
            begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY : '0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rse_ctrl.sv =====
// Controller for the Reed-Solomon parity generator: degree register, sequencer
// FSM, step counter and output valid. Depends on rse_pkg.
`default_nettype none

module rse_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rse_pkg::DEG_W-1:0]  ecc_degree,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       last_in,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output rse_pkg::cmd_t                   cmd
);
    import rse_pkg::*;

    state_t             state_reg, state_next;
    logic [DEG_W-1:0]   deg_reg, deg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   deg_m1;
    logic               out_free;
    logic               cnt_done;

    // Clamp the degree into 1..MAX_DEGREE, kept as degree minus one.
    always_comb
    begin
        if (deg_reg == '0)
        begin
            deg_m1 = '0;
        end
        else if ({1'b0, deg_reg} > (DEG_W + 1)'(MAX_DEGREE))
        begin
            deg_m1 = CNT_W'(MAX_DEGREE - 1);
        end
        else
        begin
            deg_m1 = CNT_W'(deg_reg - 1'b1);
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_done  = (cnt_reg == deg_m1);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        deg_next      = deg_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.deg_m1    = deg_m1;

        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DERIVE;
            end
            ST_DERIVE:
            begin
                cmd.derive = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    deg_next   = ecc_degree;
                    state_next = ST_INIT;
                end
                else if (in_valid)
                begin
                    cmd.absorb = 1'b1;
                    if (last_in)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = cnt_done;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_done)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        out_valid_next = (out_valid_reg && out_stall) || cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            deg_reg       <= DEG_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deg_reg       <= deg_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (state_reg == ST_INIT))
        else $error("degree write did not restart derivation");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted parity word not shown on output");

    a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> (state_reg == ST_IDLE))
        else $error("final parity word did not return to idle");

    a_no_absorb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.absorb)
        else $error("data word absorbed outside idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rse_datapath.sv =====
// Datapath for the Reed-Solomon parity generator: generator and remainder
// registers, shared GF(2^8) multipliers, output word register. Depends on rse_pkg.
`default_nettype none

module rse_datapath (
    input  wire logic                       clk,
    input  wire rse_pkg::cmd_t              cmd,
    input  wire logic [rse_pkg::BYTE_W-1:0] data_byte,
    output logic [rse_pkg::BYTE_W-1:0]      parity_byte,
    output logic                            last_out
);
    import rse_pkg::*;

    logic [BYTE_W-1:0] gen_reg  [MAX_DEGREE];
    logic [BYTE_W-1:0] gen_next [MAX_DEGREE];
    logic [BYTE_W-1:0] rem_reg  [MAX_DEGREE];
    logic [BYTE_W-1:0] rem_next [MAX_DEGREE];
    logic [BYTE_W-1:0] prod     [MAX_DEGREE];
    logic [BYTE_W-1:0] root_reg, root_next;
    logic [BYTE_W-1:0] parity_reg, parity_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] mul_b;

    // One multiplier per tap: root during derivation, feedback while encoding.
    assign mul_b = cmd.derive ? root_reg : (data_byte ^ rem_reg[0]);

    always_comb
    begin
        for (int j = 0; j < MAX_DEGREE; j++)
        begin
            prod[j] = gf_mul(gen_reg[j], mul_b);
        end
    end

    always_comb
    begin
        root_next   = root_reg;
        parity_next = parity_reg;
        last_next   = last_reg;
        for (int j = 0; j < MAX_DEGREE; j++)
        begin
            gen_next[j] = gen_reg[j];
            rem_next[j] = rem_reg[j];
        end

        if (cmd.init)
        begin
            root_next = 8'h01;
            for (int j = 0; j < MAX_DEGREE; j++)
            begin
                gen_next[j] = (CNT_W'(j) == cmd.deg_m1) ? 8'h01 : 8'h00;
                rem_next[j] = '0;
            end
        end
        else if (cmd.derive)
        begin
            // Multiply the running product by (x - root); taps past the degree stay zero.
            root_next = gf_xtime(root_reg);
            for (int j = 0; j < MAX_DEGREE; j++)
            begin
                gen_next[j] = prod[j] ^ ((j + 1 < MAX_DEGREE) ? gen_reg[(j + 1) % MAX_DEGREE]
                                                              : 8'h00);
            end
        end
        else if (cmd.absorb)
        begin
            for (int j = 0; j < MAX_DEGREE; j++)
            begin
                rem_next[j] = prod[j] ^ ((j + 1 < MAX_DEGREE) ? rem_reg[(j + 1) % MAX_DEGREE]
                                                              : 8'h00);
            end
        end
        else if (cmd.emit)
        begin
            // Shift out the head; zeros fill in so the remainder ends cleared.
            parity_next = rem_reg[0];
            last_next   = cmd.emit_last;
            for (int j = 0; j < MAX_DEGREE; j++)
            begin
                rem_next[j] = (j + 1 < MAX_DEGREE) ? rem_reg[(j + 1) % MAX_DEGREE] : 8'h00;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg   <= root_next;
        parity_reg <= parity_next;
        last_reg   <= last_next;
        for (int j = 0; j < MAX_DEGREE; j++)
        begin
            gen_reg[j] <= gen_next[j];
            rem_reg[j] <= rem_next[j];
        end
    end

    assign parity_byte = parity_reg;
    assign last_out    = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/reed_solomon_ecc_encoder.sv =====
// Throughput: one data word per cycle while idle with no degree write pending; a word
//   flagged last then holds input while d parity words (d = degree, 1..32) drain, one
//   per cycle unless out_stall holds them; each is registered from the emit state.
// Reset and every degree write run init and derive steps to build the generator
//   from one shared multiplier per tap; input is held until that finishes (degree 10).
// Reset is asynchronous, active low; the remainder restarts from zero.
`default_nettype none

module reed_solomon_ecc_encoder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // degree register write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rse_pkg::DEG_W-1:0]  ecc_degree,
    // data word input
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [rse_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       last_in,
    // parity word output
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [rse_pkg::BYTE_W-1:0]      parity_byte,
    output logic                            last_out
);
    import rse_pkg::*;

    cmd_t cmd;

    // Sequencer: owns the degree, the step counter and the output valid flag.
    rse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .ecc_degree (ecc_degree),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd)
    );

    // Datapath: generator taps, remainder LFSR and the parity word register.
    rse_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .parity_byte (parity_byte),
        .last_out    (last_out)
    );

endmodule

`default_nettype wire
